// ===== sv/top_k_light_selector_top_assert.svh =====
// Assertion macros for the light selector
`ifndef TOP_K_LIGHT_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_LIGHT_SELECTOR_TOP_ASSERT_SVH

// condition that holds in the same cycle
`define TKLS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cause implies effect in the cycle after
`define TKLS_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ===== sv/tkls_pkg.sv =====
`default_nettype none
package tkls_pkg;
  localparam int MAX_KEEP_DEF   = 32;
  localparam int INDEX_BITS_DEF = 8;
  localparam int KEPT_W         = 6;
  localparam int SCORE_W        = 32;
  localparam int POS_W          = 32;
  localparam int COLOR_W        = 16;
  localparam int RINV_W         = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int MAXL_W         = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIGHTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_PIPE, S_EMIT} state_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== sv/tkls_if.sv =====
`default_nettype none
interface tkls_in_if;
  logic valid;
  logic ready;
  logic signed [tkls_pkg::POS_W-1:0] light_x;
  logic signed [tkls_pkg::POS_W-1:0] light_y;
  logic signed [tkls_pkg::POS_W-1:0] light_z;
  logic [tkls_pkg::COLOR_W-1:0] red;
  logic [tkls_pkg::COLOR_W-1:0] green;
  logic [tkls_pkg::COLOR_W-1:0] blue;
  logic [tkls_pkg::RINV_W-1:0] range_inverse;
  logic final_light;
  modport source (output valid, light_x, light_y, light_z, red, green, blue,
                  range_inverse, final_light, input ready);
  modport sink (input valid, light_x, light_y, light_z, red, green, blue,
                range_inverse, final_light, output ready);
endinterface

interface tkls_out_if #(parameter int INDEX_BITS = tkls_pkg::INDEX_BITS_DEF);
  logic valid;
  logic ready;
  logic [INDEX_BITS-1:0] light_index;
  logic last_of_run;
  logic [tkls_pkg::KEPT_W-1:0] kept_count;
  modport source (output valid, light_index, last_of_run, kept_count, input ready);
  modport sink (input valid, light_index, last_of_run, kept_count, output ready);
endinterface
`default_nettype wire

// ===== sv/tkls_score.sv =====
`default_nettype none
module tkls_score (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [tkls_pkg::POS_W-1:0] org_x,
  input  wire logic signed [tkls_pkg::POS_W-1:0] org_y,
  input  wire logic signed [tkls_pkg::POS_W-1:0] org_z,
  input  wire logic signed [tkls_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [tkls_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [tkls_pkg::POS_W-1:0] pos_z,
  input  wire logic [tkls_pkg::COLOR_W-1:0] red,
  input  wire logic [tkls_pkg::COLOR_W-1:0] green,
  input  wire logic [tkls_pkg::COLOR_W-1:0] blue,
  input  wire logic [tkls_pkg::RINV_W-1:0] rinv,
  output logic done,
  output logic [tkls_pkg::SCORE_W-1:0] score
);
  import tkls_pkg::*;

  logic [4:0] vld;
  // stage 1
  logic [32:0] mag_x, mag_y, mag_z;
  logic [17:0] sum1;
  logic [15:0] q1;
  logic [RINV_W-1:0] rinv1;
  // stage 2
  logic [56:0] p_x, p_y, p_z;
  logic [31:0] inten2;
  // stage 3
  logic [47:0] sq_x, sq_y, sq_z;
  logic over3;
  logic [31:0] inten3;
  // stage 4
  logic [24:0] fac4;
  logic [31:0] inten4;
  // stage 5
  logic [56:0] prod5;

  logic signed [32:0] d_x, d_y, d_z;
  logic [17:0] sum0;
  logic [35:0] qprod;
  logic [17:0] rem;
  logic [15:0] low;
  logic [49:0] t4;

  always_comb begin
    d_x = 33'(pos_x) - 33'(org_x);
    d_y = 33'(pos_y) - 33'(org_y);
    d_z = 33'(pos_z) - 33'(org_z);
    sum0 = 18'(red) + 18'(green) + 18'(blue);
    // floor(sum / 3) by reciprocal, exact below 2^18
    qprod = 36'(sum0) * 36'd174763;
    rem = sum1 - 18'(q1) * 18'd3;
    unique case (rem[1:0])
      2'd1:    low = 16'd21845;
      2'd2:    low = 16'd43690;
      default: low = 16'd0;
    endcase
    t4 = 50'(sq_x) + 50'(sq_y) + 50'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= d_x[32] ? 33'(-d_x) : 33'(d_x);
    mag_y <= d_y[32] ? 33'(-d_y) : 33'(d_y);
    mag_z <= d_z[32] ? 33'(-d_z) : 33'(d_z);
    sum1  <= sum0;
    q1    <= qprod[34:19];
    rinv1 <= rinv;

    p_x <= 57'(mag_x) * 57'(rinv1);
    p_y <= 57'(mag_y) * 57'(rinv1);
    p_z <= 57'(mag_z) * 57'(rinv1);
    inten2 <= {q1, 16'd0} + 32'(low);

    sq_x <= 48'(p_x[39:16]) * 48'(p_x[39:16]);
    sq_y <= 48'(p_y[39:16]) * 48'(p_y[39:16]);
    sq_z <= 48'(p_z[39:16]) * 48'(p_z[39:16]);
    over3 <= (|p_x[56:40]) | (|p_y[56:40]) | (|p_z[56:40]);
    inten3 <= inten2;

    if (over3 || t4[49:48] != 2'd0) begin
      fac4 <= '0;
    end else begin
      fac4 <= 25'((50'd1 << 48) - t4 >> 24);
    end
    inten4 <= inten3;

    prod5 <= 57'(inten4) * 57'(fac4);
  end

  assign done  = vld[4];
  assign score = (prod5[56] != 1'b0) ? '1 : prod5[55:24];
endmodule
`default_nettype wire

// ===== sv/tkls_cell.sv =====
`default_nettype none
module tkls_cell #(
  parameter int INDEX_BITS = tkls_pkg::INDEX_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tkls_pkg::cell_ctl_t ctl,
  input  wire logic live,
  input  wire logic [tkls_pkg::SCORE_W-1:0] new_score,
  input  wire logic [INDEX_BITS-1:0] new_index,
  input  wire logic take_left,
  input  wire logic left_valid,
  input  wire logic [tkls_pkg::SCORE_W-1:0] left_score,
  input  wire logic [INDEX_BITS-1:0] left_index,
  input  wire logic right_valid,
  input  wire logic [tkls_pkg::SCORE_W-1:0] right_score,
  input  wire logic [INDEX_BITS-1:0] right_index,
  output logic take,
  output logic mvalid,
  output logic valid,
  output logic [tkls_pkg::SCORE_W-1:0] score,
  output logic [INDEX_BITS-1:0] index
);
  import tkls_pkg::*;

  assign mvalid = valid & live;
  // new light goes before this entry only on a strictly greater score
  assign take = !mvalid || (new_score > score);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.ins) begin
      if (!live) begin
        valid <= 1'b0;
      end else if (take_left) begin
        valid <= left_valid;
      end else if (take) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      score <= right_score;
      index <= right_index;
    end else if (ctl.ins && live) begin
      if (take_left) begin
        score <= left_score;
        index <= left_index;
      end else if (take) begin
        score <= new_score;
        index <= new_index;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/top_k_light_selector_top.sv =====
`default_nettype none
// Light selector: keeps the K best-scoring lights of a set in a sorted cell chain.
// The first of five score stages loads at the accept edge, and the chain inserts
// at the edge after the last stage loads; no new light is taken before that insert.
// On a final light the selected indices follow at one per cycle while picks.ready is high.
// Reset (rst, synchronous): config to defaults (K = 4, origin 0), chain empty,
// light counter zero; no clearing pass is needed.
module top_k_light_selector_top #(
  parameter int MAX_KEEP   = tkls_pkg::MAX_KEEP_DEF,
  parameter int INDEX_BITS = tkls_pkg::INDEX_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [tkls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tkls_pkg::CFG_DATA_W-1:0] cfg_data,
  tkls_in_if.sink lights,
  tkls_out_if.source picks
);
  import tkls_pkg::*;

  localparam int KW = $clog2(MAX_KEEP + 1);
  localparam int CW = (INDEX_BITS > KW) ? INDEX_BITS : KW;

  // configuration registers
  logic [MAXL_W-1:0] max_lights;
  logic signed [POS_W-1:0] origin_x, origin_y, origin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lights <= MAXL_W'(4);
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LIGHTS: max_lights <= cfg_data[MAXL_W-1:0];
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_ORIGIN_Z:   origin_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective K: zero acts as one, clip at the chain length
  logic [KW-1:0] k_eff;
  always_comb begin
    if (max_lights == '0) begin
      k_eff = KW'(1);
    end else if (32'(max_lights) > 32'(MAX_KEEP)) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = KW'(max_lights);
    end
  end

  state_t state, state_next;
  logic [INDEX_BITS-1:0] counter, counter_next;
  logic [KW-1:0] filled, filled_next;
  logic [KW-1:0] cnt, cnt_next;
  logic [KW-1:0] emit_pos, emit_pos_next;
  logic in_order, in_order_next;
  logic is_final, counting;
  logic score_done;
  logic [SCORE_W-1:0] new_score;
  logic accept, out_load, emit_last;
  cell_ctl_t ctl;

  assign accept = lights.valid && lights.ready;
  assign lights.ready = (state == S_IDLE);

  // hold the flags of the light in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      is_final <= lights.final_light;
      counting <= (counter != '1);
    end
  end

  tkls_score u_score (
    .clk(clk), .rst(rst), .start(accept),
    .org_x(origin_x), .org_y(origin_y), .org_z(origin_z),
    .pos_x(lights.light_x), .pos_y(lights.light_y), .pos_z(lights.light_z),
    .red(lights.red), .green(lights.green), .blue(lights.blue),
    .rinv(lights.range_inverse),
    .done(score_done), .score(new_score)
  );

  // cell chain
  logic [MAX_KEEP-1:0] c_take, c_mv, c_valid;
  logic [SCORE_W-1:0] c_score [MAX_KEEP];
  logic [INDEX_BITS-1:0] c_index [MAX_KEEP];

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic tl, lv, rv;
    logic [SCORE_W-1:0] ls, rs;
    logic [INDEX_BITS-1:0] li, ri;
    if (i == 0) begin : g_head
      assign tl = 1'b0;
      assign lv = 1'b0;
      assign ls = '0;
      assign li = '0;
    end else begin : g_mid
      assign tl = c_take[i-1];
      assign lv = c_mv[i-1];
      assign ls = c_score[i-1];
      assign li = c_index[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_tail
      assign rv = 1'b0;
      assign rs = '0;
      assign ri = '0;
    end else begin : g_body
      assign rv = c_valid[i+1];
      assign rs = c_score[i+1];
      assign ri = c_index[i+1];
    end
    tkls_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .live(KW'(i) < k_eff),
      .new_score(new_score), .new_index(counter),
      .take_left(tl), .left_valid(lv), .left_score(ls), .left_index(li),
      .right_valid(rv), .right_score(rs), .right_index(ri),
      .take(c_take[i]), .mvalid(c_mv[i]), .valid(c_valid[i]),
      .score(c_score[i]), .index(c_index[i])
    );
  end

  // output register, loaded in the emit state when empty or being drained
  logic o_valid, o_last;
  logic [INDEX_BITS-1:0] o_index;
  logic [KEPT_W-1:0] o_kept;
  assign out_load = (state == S_EMIT) && (!o_valid || picks.ready);
  assign emit_last = (emit_pos == KW'(cnt - KW'(1)));

  logic [KW-1:0] fclip;
  logic [INDEX_BITS-1:0] n_lights;
  always_comb begin
    fclip    = (filled > k_eff) ? k_eff : filled;
    n_lights = counting ? INDEX_BITS'(counter + INDEX_BITS'(1)) : counter;
  end

  always_comb begin
    state_next    = state;
    counter_next  = counter;
    filled_next   = filled;
    cnt_next      = cnt;
    emit_pos_next = emit_pos;
    in_order_next = in_order;
    ctl           = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_PIPE;
      end
      S_PIPE: begin
        if (score_done) begin
          // drop entries beyond the current K even when nothing is inserted
          filled_next = fclip;
          // insert only below the counter ceiling
          ctl.ins = counting;
          if (counting) begin
            counter_next = n_lights;
            filled_next  = (fclip < k_eff) ? KW'(fclip + KW'(1)) : fclip;
          end
          if (is_final) begin
            in_order_next = (CW'(n_lights) <= CW'(k_eff));
            cnt_next      = in_order_next ? KW'(n_lights) : filled_next;
            emit_pos_next = '0;
            state_next    = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          emit_pos_next = KW'(emit_pos + KW'(1));
          if (emit_last) begin
            ctl.clr      = 1'b1;
            counter_next = '0;
            filled_next  = '0;
            state_next   = S_IDLE;
          end else begin
            // advance the chain toward the head
            ctl.shift = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      counter <= '0;
      filled  <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      counter <= counter_next;
      filled  <= filled_next;
      if (out_load) begin
        o_valid <= 1'b1;
      end else if (picks.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    emit_pos <= emit_pos_next;
    in_order <= in_order_next;
    if (out_load) begin
      o_index <= in_order ? INDEX_BITS'(emit_pos) : c_index[0];
      o_last  <= emit_last;
      o_kept  <= KEPT_W'(cnt);
    end
  end

  assign picks.valid       = o_valid;
  assign picks.light_index = o_index;
  assign picks.last_of_run = o_last;
  assign picks.kept_count  = o_kept;

`include "top_k_light_selector_top_assert.svh"
  `TKLS_ASSERT(a_kept_nonzero, !picks.valid || picks.kept_count != '0, "empty run emitted")
  `TKLS_ASSERT(a_done_in_pipe, !score_done || state == S_PIPE, "score outside pipe state")
  `TKLS_ASSERT(a_fill_bound, filled <= KW'(MAX_KEEP), "fill count exceeds chain")
  `TKLS_ASSERT_NEXT(a_run_end, out_load && emit_last, state == S_IDLE, "run did not end")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  import tkls_pkg::*;

  // One light request as the sender sees it.
  typedef struct {
    logic signed [POS_W-1:0] light_x;
    logic signed [POS_W-1:0] light_y;
    logic signed [POS_W-1:0] light_z;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic [RINV_W-1:0]       range_inverse;
    logic                    final_light;
  } light_t;

  // One selected index as the receiver sees it.
  typedef struct {
    logic [INDEX_BITS_DEF-1:0] light_index;
    logic                      last_of_run;
    logic [KEPT_W-1:0]         kept_count;
  } pick_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;   // well past the time a light occupies the block
  localparam int COUNT_MAX = (1 << INDEX_BITS_DEF) - 1;
  localparam int RANDOM_LIGHTS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_LIGHTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tkls_in_if lights();
  tkls_out_if picks();

  top_k_light_selector_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .lights(lights), .picks(picks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: configuration, sorted list and set counters.
  logic [MAXL_W-1:0]       keep_reg;
  logic signed [POS_W-1:0] org_x, org_y, org_z;
  logic [SCORE_W-1:0]      ranked_score [MAX_KEEP_DEF];
  int                      ranked_index [MAX_KEEP_DEF];
  int                      ranked_filled;
  int                      set_count;

  light_t pending_lights[$];
  pick_t  expected_picks[$];
  int     error_count = 0;
  int     cycle_count = 0;
  logic   stream_on = 1'b0;

  function automatic logic [63:0] axis_ratio(logic signed [POS_W-1:0] pos,
                                             logic signed [POS_W-1:0] org,
                                             logic [RINV_W-1:0] rinv);
    longint d;
    logic [63:0] mag;
    d = longint'(pos) - longint'(org);
    mag = (d < 0) ? -d : d;
    return (mag * {40'd0, rinv}) >> 16;
  endfunction

  // Mean intensity scaled by how far inside the light's range the origin sits.
  function automatic logic [SCORE_W-1:0] light_score(light_t l);
    logic [63:0] inten, ux, uy, uz, t, factor, s;
    inten = (({48'd0, l.red} + {48'd0, l.green} + {48'd0, l.blue}) << 16) / 64'd3;
    ux = axis_ratio(l.light_x, org_x, l.range_inverse);
    uy = axis_ratio(l.light_y, org_y, l.range_inverse);
    uz = axis_ratio(l.light_z, org_z, l.range_inverse);
    factor = 64'd0;
    if (ux < (64'd1 << 24) && uy < (64'd1 << 24) && uz < (64'd1 << 24)) begin
      t = ux * ux + uy * uy + uz * uz;
      if (t < (64'd1 << 48)) factor = ((64'd1 << 48) - t) >> 24;
    end
    s = (inten * factor) >> 24;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return s[SCORE_W-1:0];
  endfunction

  // Insert one light into the ranked list; on a final light queue the picks.
  task automatic rank_light(light_t l);
    int k, p, last_slot, n, cnt;
    logic [SCORE_W-1:0] s;
    pick_t r;
    k = (keep_reg < 1) ? 1 : ((keep_reg > MAX_KEEP_DEF) ? MAX_KEEP_DEF : int'(keep_reg));
    if (ranked_filled > k) ranked_filled = k;
    if (set_count < COUNT_MAX) begin
      s = light_score(l);
      p = 0;
      while (p < ranked_filled && !(s > ranked_score[p])) p++;
      if (p < k) begin
        last_slot = (ranked_filled < k) ? ranked_filled : k - 1;
        for (int j = last_slot; j > p; j--) begin
          ranked_score[j] = ranked_score[j-1];
          ranked_index[j] = ranked_index[j-1];
        end
        ranked_score[p] = s;
        ranked_index[p] = set_count;
        if (ranked_filled < k) ranked_filled++;
      end
      set_count++;
    end
    if (l.final_light) begin
      n = set_count;
      // few lights: arrival order, not score order
      cnt = (n <= k) ? n : ranked_filled;
      if (cnt > MAX_KEEP_DEF) cnt = MAX_KEEP_DEF;
      for (int i = 0; i < cnt; i++) begin
        r.light_index = INDEX_BITS_DEF'((n <= k) ? i : ranked_index[i]);
        r.last_of_run = (i + 1 == cnt);
        r.kept_count = KEPT_W'(cnt);
        expected_picks.push_back(r);
      end
      set_count = 0;
      ranked_filled = 0;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int   burst_left = 0;
  int   gap_left = 0;
  logic took_light = 1'b0;

  always @(negedge clk) begin
    light_t l;
    logic drive;
    drive = lights.valid && !took_light;  // hold an unaccepted request
    if (!rst && !drive && stream_on && pending_lights.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        l = pending_lights.pop_front();
        lights.light_x <= l.light_x;
        lights.light_y <= l.light_y;
        lights.light_z <= l.light_z;
        lights.red <= l.red;
        lights.green <= l.green;
        lights.blue <= l.blue;
        lights.range_inverse <= l.range_inverse;
        lights.final_light <= l.final_light;
        drive = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 6);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
        end
      end
    end
    lights.valid <= drive;
  end

  // Receiver: stall pattern that changes its character now and then.
  int stall_mode = 0;

  always @(negedge clk) begin
    if (cycle_count % 400 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: picks.ready <= 1'b1;
      1: picks.ready <= $urandom_range(0, 3) != 0;
      2: picks.ready <= (cycle_count % 5) != 0;
      default: picks.ready <= cycle_count[3];
    endcase
  end

  // Monitor: predict on each accepted light, check each accepted pick.
  always @(posedge clk) begin
    light_t l;
    pick_t want;
    cycle_count <= cycle_count + 1;
    took_light <= !rst && lights.valid && lights.ready;
    if (!rst) begin
      if (lights.valid && lights.ready) begin
        l.light_x = lights.light_x;
        l.light_y = lights.light_y;
        l.light_z = lights.light_z;
        l.red = lights.red;
        l.green = lights.green;
        l.blue = lights.blue;
        l.range_inverse = lights.range_inverse;
        l.final_light = lights.final_light;
        rank_light(l);
      end
      if (picks.valid && picks.ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected pick index %0d last %0b count %0d", $time,
                   picks.light_index, picks.last_of_run, picks.kept_count);
          error_count++;
        end else begin
          want = expected_picks.pop_front();
          if (picks.light_index !== want.light_index) begin
            $display("%0t: light_index expected %0d actual %0d", $time,
                     want.light_index, picks.light_index);
            error_count++;
          end
          if (picks.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time,
                     want.last_of_run, picks.last_of_run);
            error_count++;
          end
          if (picks.kept_count !== want.kept_count) begin
            $display("%0t: kept_count expected %0d actual %0d", $time,
                     want.kept_count, picks.kept_count);
            error_count++;
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d picks outstanding", $time, expected_picks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register while the block is idle and mirror it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_LIGHTS: keep_reg = val[MAXL_W-1:0];
      REG_ORIGIN_X: org_x = val;
      REG_ORIGIN_Y: org_y = val;
      default: org_z = val;
    endcase
  endtask

  // Hold until every request is taken and every pick is back, then let the
  // last non-final light clear the pipeline.
  task automatic drain();
    while (pending_lights.size() > 0 || lights.valid || expected_picks.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A light inside its range around the origin, or fully random.
  function automatic light_t make_light(logic fin);
    light_t l;
    if ($urandom_range(0, 3) != 0) begin
      l.light_x = org_x + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      l.light_y = org_y + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      l.light_z = org_z + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      l.range_inverse = RINV_W'($urandom_range(0, 1 << 21));
    end else begin
      l.light_x = $urandom;
      l.light_y = $urandom;
      l.light_z = $urandom;
      l.range_inverse = RINV_W'($urandom);
    end
    l.red = COLOR_W'($urandom);
    l.green = COLOR_W'($urandom);
    l.blue = COLOR_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      l.red = COLOR_W'($urandom_range(0, 3));
      l.green = l.red;
      l.blue = l.red;
    end
    l.final_light = fin;
    return l;
  endfunction

  task automatic queue_set(int len);
    light_t l;
    for (int i = 0; i < len; i++) begin
      // repeat the previous light now and then to force score ties
      if (i == 0 || $urandom_range(0, 5) != 0) l = make_light(1'b0);
      l.final_light = (i == len - 1);
      pending_lights.push_back(l);
    end
  endtask

  initial begin
    light_t l;
    int sent;
    int len;
    keep_reg = 4;
    org_x = 0;
    org_y = 0;
    org_z = 0;
    ranked_filled = 0;
    set_count = 0;
    lights.valid = 1'b0;
    lights.light_x = '0;
    lights.light_y = '0;
    lights.light_z = '0;
    lights.red = '0;
    lights.green = '0;
    lights.blue = '0;
    lights.range_inverse = '0;
    lights.final_light = 1'b0;
    picks.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    stream_on = 1'b1;

    // Defaults: a lone light, exactly K lights, then K+1 lights.
    queue_set(1);
    queue_set(4);
    queue_set(5);
    drain();

    // Extremes: origin at a corner (x and y most negative, z most positive), lights at
    // both corners, full and zero intensity, zero and full inverse range.
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(REG_ORIGIN_Z, 32'h7FFF_FFFF);
    write_reg(REG_MAX_LIGHTS, 1);
    l = make_light(1'b0);
    l.light_x = 32'h7FFF_FFFF; l.light_y = 32'h8000_0000; l.light_z = 32'h8000_0000;
    l.red = 16'hFFFF; l.green = 16'hFFFF; l.blue = 16'hFFFF; l.range_inverse = '0;
    pending_lights.push_back(l);
    l.range_inverse = 24'hFFFFFF;
    pending_lights.push_back(l);
    l.light_x = 32'h8000_0000; l.light_z = 32'h7FFF_FFFF; l.range_inverse = 24'h000001;
    pending_lights.push_back(l);
    l.red = '0; l.green = '0; l.blue = '0; l.final_light = 1'b1;
    pending_lights.push_back(l);
    drain();

    // K of zero acts as one; above the cap acts as the cap.
    write_reg(REG_MAX_LIGHTS, 0);
    queue_set(3);
    drain();
    write_reg(REG_MAX_LIGHTS, 63);
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_ORIGIN_Z, 0);
    queue_set(40);
    drain();

    // K shrinks, then grows, inside one set.
    write_reg(REG_MAX_LIGHTS, 8);
    for (int i = 0; i < 10; i++) pending_lights.push_back(make_light(1'b0));
    drain();
    write_reg(REG_MAX_LIGHTS, 3);
    for (int i = 0; i < 2; i++) pending_lights.push_back(make_light(1'b0));
    drain();
    write_reg(REG_MAX_LIGHTS, 32);
    queue_set(4);
    drain();

    // More lights than the index counter holds: the tail is ignored.
    write_reg(REG_MAX_LIGHTS, 5);
    queue_set(COUNT_MAX + 8);
    drain();

    // Random sets, with a fresh configuration every few sets.
    sent = 0;
    while (sent < RANDOM_LIGHTS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(REG_MAX_LIGHTS, $urandom_range(0, 4) == 0 ? $urandom_range(0, 63)
                                                         : $urandom_range(1, 12));
        write_reg(REG_ORIGIN_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
        write_reg(REG_ORIGIN_Y, $urandom);
        write_reg(REG_ORIGIN_Z, $urandom_range(0, 1) ? 32'h0 : $urandom);
      end
      len = $urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 12);
      queue_set(len);
      sent += len;
      while (pending_lights.size() > 8) @(negedge clk);
    end
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/tkls_pkg.sv
sv/tkls_if.sv
sv/tkls_score.sv
sv/tkls_cell.sv
sv/top_k_light_selector_top.sv
test/tb_top.sv
